// ===== hdl/ics_pkg.sv =====
// Shared types, chip tables and vector helpers for the logic IC identifier sequencer.
// No dependencies; imported by ics_eval, logic_ic_identifier_sequencer and the testbench.
`default_nettype none

package ics_pkg;

   // Beat widths
   localparam int PinW   = 12;
   localparam int ChipW  = 3;
   localparam int PosW   = 5;
   localparam int NChips = 6;

   // Item function codes
   localparam logic FUNC_START  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Chip codes in search order
   localparam logic [ChipW-1:0] CHIP_7404      = 3'd0;
   localparam logic [ChipW-1:0] CHIP_7411      = 3'd5;
   localparam logic [ChipW-1:0] LAST_CHIP      = CHIP_7411;
   localparam logic [ChipW-1:0] CHIP_UNDEFINED = 3'd6;

   localparam logic [PinW-1:0] ALL_HIGH = 12'hFFF;

   // Per-chip gate geometry
   localparam logic [1:0] N_INPUTS [NChips] = '{2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3};
   localparam logic [2:0] N_GATES  [NChips] = '{3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3};
   // bit c = expected output for input combination c, first input pin as MSB
   localparam logic [7:0] TRUTH    [NChips] = '{8'h01, 8'h07, 8'h0E, 8'h08, 8'h06, 8'h80};

   // Gate input pins, per chip and gate
   localparam logic [3:0] GATE_IN [NChips][6][3] = '{
      '{'{4'd0, 4'd0, 4'd0}, '{4'd2, 4'd0, 4'd0}, '{4'd4, 4'd0, 4'd0},
        '{4'd7, 4'd0, 4'd0}, '{4'd9, 4'd0, 4'd0}, '{4'd11, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd11}, '{4'd2, 4'd3, 4'd4}, '{4'd9, 4'd8, 4'd7},
        '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}}
   };

   // Gate output pin, per chip and gate
   localparam logic [3:0] GATE_OUT [NChips][6] = '{
      '{4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd10, 4'd5, 4'd6, 4'd0, 4'd0, 4'd0}
   };

   // Search state carried between items
   typedef struct packed {
      logic [ChipW-1:0] chip;
      logic [PosW-1:0]  pos;
      logic             active;
   } ics_state_type;

   // One result beat
   typedef struct packed {
      logic [PinW-1:0]  drive_pattern;
      logic             test_done;
      logic [ChipW-1:0] chip_code;
   } ics_result_type;

   // Number of vectors of a chip: gates times input combinations
   function automatic logic [PosW-1:0] vector_count(input logic [ChipW-1:0] chip);
      return PosW'({2'b00, N_GATES[chip]} << N_INPUTS[chip]);
   endfunction

   // Gate index of a vector position
   function automatic logic [3:0] gate_of(input logic [ChipW-1:0] chip,
                                          input logic [PosW-1:0]  pos);
      return 4'(pos >> N_INPUTS[chip]);
   endfunction

   // Input combination of a vector position
   function automatic logic [2:0] combo_of(input logic [ChipW-1:0] chip,
                                           input logic [PosW-1:0]  pos);
      logic [2:0] mask;
      mask = 3'((4'd1 << N_INPUTS[chip]) - 4'd1);
      return pos[2:0] & mask;
   endfunction

   // Drive word for a vector: current gate's inputs carry the combination
   function automatic logic [PinW-1:0] drive_for(input logic [ChipW-1:0] chip,
                                                 input logic [PosW-1:0]  pos);
      logic [1:0]      n;
      logic [3:0]      gate;
      logic [2:0]      combo;
      logic [1:0]      bit_idx;
      logic [3:0]      pin;
      logic [PinW-1:0] word;
      int              i;
      n     = N_INPUTS[chip];
      gate  = gate_of(chip, pos);
      combo = combo_of(chip, pos);
      word  = ALL_HIGH;
      if (gate < {1'b0, N_GATES[chip]}) begin
         for (i = 0; i < 3; i++) begin
            if (i < int'(n)) begin
               bit_idx = 2'(n - 2'd1 - 2'(i));
               pin     = GATE_IN[chip][gate[2:0]][i];
               if (!combo[bit_idx]) begin
                  word[pin] = 1'b0;
               end
            end
         end
      end
      return word;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ics_eval.sv =====
// Single-pass evaluation of one item: pin check, position update and drive lookup.
// Depends on ics_pkg for the chip tables and state/result types.
`default_nettype none

module ics_eval
   import ics_pkg::*;
(
   input  wire logic             func,
   input  wire logic [PinW-1:0]  pin_levels,
   input  wire ics_state_type    state_cur,
   output ics_state_type         state_nxt,
   output ics_result_type        result
);

   logic [ChipW-1:0] chip;
   logic [PosW-1:0]  count;
   logic [3:0]       gate;
   logic [2:0]       combo;
   logic             expect_lvl;
   logic             seen_lvl;
   logic             match;
   logic [PosW:0]    pos_inc;
   logic             done;

   // Clamp the chip index and look up the vector being checked
   always_comb begin
      chip       = (state_cur.chip > LAST_CHIP) ? LAST_CHIP : state_cur.chip;
      count      = vector_count(chip);
      gate       = gate_of(chip, state_cur.pos);
      combo      = combo_of(chip, state_cur.pos);
      expect_lvl = TRUTH[chip][combo];
      seen_lvl   = 1'b1;
      if (state_cur.pos < count) begin
         seen_lvl = pin_levels[GATE_OUT[chip][gate[2:0]]];
      end
      // a position past the end counts as a completed chip
      match   = (state_cur.pos >= count) || (seen_lvl == expect_lvl);
      pos_inc = {1'b0, state_cur.pos} + 6'd1;
   end

   // Next state and result beat
   always_comb begin
      state_nxt            = state_cur;
      result.drive_pattern = ALL_HIGH;
      result.test_done     = 1'b0;
      result.chip_code     = CHIP_7404;
      done                 = 1'b0;
      if (func == FUNC_START) begin
         state_nxt.chip       = CHIP_7404;
         state_nxt.pos        = '0;
         state_nxt.active     = 1'b1;
         result.drive_pattern = drive_for(CHIP_7404, '0);
      end else if (state_cur.active) begin
         if (match) begin
            if (pos_inc >= {1'b0, count}) begin
               done             = 1'b1;
               result.chip_code = chip;
            end else begin
               state_nxt.chip       = chip;
               state_nxt.pos        = pos_inc[PosW-1:0];
               result.drive_pattern = drive_for(chip, pos_inc[PosW-1:0]);
            end
         end else if (chip >= LAST_CHIP) begin
            done             = 1'b1;
            result.chip_code = CHIP_UNDEFINED;
         end else begin
            state_nxt.chip       = chip + 3'd1;
            state_nxt.pos        = '0;
            result.drive_pattern = drive_for(chip + 3'd1, '0);
         end
         // conclusion: everything back high and idle
         if (done) begin
            state_nxt.active     = 1'b0;
            state_nxt.chip       = CHIP_7404;
            state_nxt.pos        = '0;
            result.drive_pattern = ALL_HIGH;
            result.test_done     = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/logic_ic_identifier_sequencer.sv =====
// Top level of the logic IC identifier sequencer: input register, search state, result register.
// Depends on ics_pkg and ics_eval.
`default_nettype none

// Identifies a 14-pin gate package (7404, 7400, 7432, 7408, 7486, 7411, tried in
// that order). A start beat (func 0) returns the drive pattern of the first 7404
// vector; each sample beat (func 1) in a search checks one gate output against the
// table and returns the next drive pattern, or test_done with the chip code (6 = undefined).
// Each beat passes through an input register and then a result register, where its
// result is presented, and one beat per cycle is sustained while rsp_stall is low:
// the table lookup, one-bit compare and position update all sit in a single stage.
// A waiting result lets one beat enter an empty input register; further beats stall.
module logic_ic_identifier_sequencer
   import ics_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_func,
   input  wire logic [PinW-1:0]  req_pin_levels,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [PinW-1:0]       rsp_drive_pattern,
   output logic                  rsp_test_done,
   output logic [ChipW-1:0]      rsp_chip_code
);

   logic            in_valid_ff, in_valid_in;
   logic            in_func_ff;
   logic [PinW-1:0] in_pins_ff;
   ics_state_type   state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   ics_result_type  out_ff;
   ics_result_type  eval_result;
   logic            out_free;
   logic            advance;

   // Handshake: the input stage moves on when the result register can take it
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   ics_eval u_eval (
      .func       (in_func_ff),
      .pin_levels (in_pins_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .result     (eval_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_func_ff <= req_func;
         in_pins_ff <= req_pin_levels;
      end
      if (advance) begin
         out_ff <= eval_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drive_pattern = out_ff.drive_pattern;
   assign rsp_test_done     = out_ff.test_done;
   assign rsp_chip_code     = out_ff.chip_code;

endmodule

`default_nettype wire

// ===== tb/ics_search_checker.sv =====
// Checker for the logic IC identifier sequencer: watches both channels, predicts each result beat.
// Depends on ics_pkg for beat types, widths and codes; chip tables are kept locally.
`timescale 1ns / 1ps

module ics_search_checker
   import ics_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire logic             req_func,
   input  wire logic [PinW-1:0]  req_pin_levels,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [PinW-1:0]  rsp_drive_pattern,
   input  wire logic             rsp_test_done,
   input  wire logic [ChipW-1:0] rsp_chip_code,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int NumChips = 6;

   // Gate geometry and truth tables, in search order
   localparam logic [1:0] GATE_INPUTS [NumChips] = '{2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3};
   localparam logic [2:0] GATE_COUNT  [NumChips] = '{3'd6, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3};
   // bit c = gate output for input combination c, first input as MSB
   localparam logic [7:0] GATE_TRUTH  [NumChips] = '{8'h01, 8'h07, 8'h0E, 8'h08, 8'h06, 8'h80};

   localparam logic [3:0] INPUT_PIN [NumChips][6][3] = '{
      '{'{4'd0, 4'd0, 4'd0}, '{4'd2, 4'd0, 4'd0}, '{4'd4, 4'd0, 4'd0},
        '{4'd7, 4'd0, 4'd0}, '{4'd9, 4'd0, 4'd0}, '{4'd11, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd0}, '{4'd3, 4'd4, 4'd0}, '{4'd8, 4'd7, 4'd0},
        '{4'd11, 4'd10, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}},
      '{'{4'd0, 4'd1, 4'd11}, '{4'd2, 4'd3, 4'd4}, '{4'd9, 4'd8, 4'd7},
        '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}}
   };

   localparam logic [3:0] OUTPUT_PIN [NumChips][6] = '{
      '{4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd2, 4'd5, 4'd6, 4'd9, 4'd0, 4'd0},
      '{4'd10, 4'd5, 4'd6, 4'd0, 4'd0, 4'd0}
   };

   // Predicted search state
   logic [ChipW-1:0] chip_q;
   logic [PosW-1:0]  pos_q;
   logic             searching_q;

   ics_result_type expected_results [$];
   int             errors = 0;

   assign fail_count = errors;

   // Vectors in one chip's test
   function automatic int vectors_of(input int chip);
      return int'(GATE_COUNT[chip]) << GATE_INPUTS[chip];
   endfunction

   // Drive word for a vector: the gate under test gets its combination, all else high
   function automatic logic [PinW-1:0] drive_word(input int chip, input int pos);
      int              n;
      int              gate;
      int              combo;
      logic [PinW-1:0] word;
      n     = GATE_INPUTS[chip];
      gate  = pos >> n;
      combo = pos & ((1 << n) - 1);
      word  = ALL_HIGH;
      if (gate < int'(GATE_COUNT[chip])) begin
         for (int i = 0; i < n; i++) begin
            if (((combo >> (n - 1 - i)) & 1) == 0) begin
               word[INPUT_PIN[chip][gate][i]] = 1'b0;
            end
         end
      end
      return word;
   endfunction

   // Advance the predicted search by one beat and return the result it causes
   function automatic ics_result_type predict_result(input logic func,
                                                     input logic [PinW-1:0] levels);
      int             c;
      int             p;
      int             n;
      int             gate;
      int             combo;
      logic           matched;
      logic           concluded;
      ics_result_type res;
      res.drive_pattern = ALL_HIGH;
      res.test_done     = 1'b0;
      res.chip_code     = '0;
      if (func == FUNC_START) begin
         chip_q            = '0;
         pos_q             = '0;
         searching_q       = 1'b1;
         res.drive_pattern = drive_word(0, 0);
      end else if (searching_q) begin
         // out-of-range chip index behaves as the last chip
         c         = (chip_q > LAST_CHIP) ? int'(LAST_CHIP) : int'(chip_q);
         p         = int'(pos_q);
         concluded = 1'b0;
         if (p >= vectors_of(c)) begin
            matched = 1'b1;
         end else begin
            n       = GATE_INPUTS[c];
            gate    = p >> n;
            combo   = p & ((1 << n) - 1);
            matched = (levels[OUTPUT_PIN[c][gate]] == GATE_TRUTH[c][combo]);
         end
         if (matched) begin
            p++;
            if (p >= vectors_of(c)) begin
               concluded     = 1'b1;
               res.chip_code = ChipW'(c);
            end else begin
               chip_q            = ChipW'(c);
               pos_q             = PosW'(p);
               res.drive_pattern = drive_word(c, p);
            end
         end else if (c >= int'(LAST_CHIP)) begin
            concluded     = 1'b1;
            res.chip_code = CHIP_UNDEFINED;
         end else begin
            chip_q            = ChipW'(c + 1);
            pos_q             = '0;
            res.drive_pattern = drive_word(c + 1, 0);
         end
         if (concluded) begin
            res.test_done     = 1'b1;
            res.drive_pattern = ALL_HIGH;
            searching_q       = 1'b0;
            chip_q            = '0;
            pos_q             = '0;
         end
      end
      return res;
   endfunction

   // Compare result beats first; a beat taken this edge cannot be answered at the same edge
   always @(posedge clock) begin
      ics_result_type want;
      ics_result_type got;
      if (reset) begin
         chip_q      = '0;
         pos_q       = '0;
         searching_q = 1'b0;
         expected_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.drive_pattern = rsp_drive_pattern;
            got.test_done     = rsp_test_done;
            got.chip_code     = rsp_chip_code;
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result beat with none expected: drive %03h done %0b chip %0d",
                           $time, got.drive_pattern, got.test_done, got.chip_code);
            end else begin
               want = expected_results.pop_front();
               if (got.drive_pattern !== want.drive_pattern ||
                   got.test_done !== want.test_done ||
                   got.chip_code !== want.chip_code) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: result mismatch: expected drive %03h done %0b chip %0d,",
                               " got drive %03h done %0b chip %0d"}, $time,
                              want.drive_pattern, want.test_done, want.chip_code,
                              got.drive_pattern, got.test_done, got.chip_code);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_result(req_func, req_pin_levels));
         outstanding <= expected_results.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the logic IC identifier sequencer: clock, reset, stimulus and verdict.
// Depends on ics_pkg, logic_ic_identifier_sequencer and ics_search_checker.
`timescale 1ns / 1ps

module tb_top;
   import ics_pkg::*;

   logic             clock;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_func       = FUNC_START;
   logic [PinW-1:0]  req_pin_levels = '0;
   logic             rsp_stall      = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   logic [PinW-1:0]  rsp_drive_pattern;
   logic             rsp_test_done;
   logic [ChipW-1:0] rsp_chip_code;

   int fail_count;
   int outstanding;
   int sender_gap_pct = 0;
   int stall_pct      = 0;
   int hold_trigger   = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int beats_sent     = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   logic_ic_identifier_sequencer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_pattern (rsp_drive_pattern),
      .rsp_test_done     (rsp_test_done),
      .rsp_chip_code     (rsp_chip_code)
   );

   ics_search_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_pattern (rsp_drive_pattern),
      .rsp_test_done     (rsp_test_done),
      .rsp_chip_code     (rsp_chip_code),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   // Receiver: random stall, or a long hold-off each time one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Vectors in one chip's test
   function automatic int chip_vectors(input int chip);
      return int'(N_GATES[chip]) << N_INPUTS[chip];
   endfunction

   // Pin levels as a device would return them: checked pin agrees or not, rest is fill
   function automatic logic [PinW-1:0] sample_levels(input int chip, input int pos,
                                                     input bit agree,
                                                     input logic [PinW-1:0] fill);
      int              n;
      int              gate;
      int              combo;
      logic [PinW-1:0] levels;
      n      = N_INPUTS[chip];
      gate   = pos >> n;
      combo  = pos & ((1 << n) - 1);
      levels = fill;
      levels[GATE_OUT[chip][gate]] = TRUTH[chip][combo] ^ !agree;
      return levels;
   endfunction

   // Offer one beat, sometimes after a random gap, and hold it until taken
   task automatic send_beat(input logic func, input logic [PinW-1:0] levels, input bit counts);
      if ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_pin_levels <= levels;
      do @(posedge clock); while (req_stall);
      if (counts)
         beats_sent++;
   endtask

   // Stop offering until every predicted result has come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One identification aimed at a target chip; earlier chips fail at a random vector.
   // Now and then the sequence is cut short by a random beat.
   task automatic identify(input int target);
      int last;
      int fail_at;
      send_beat(FUNC_START, PinW'($urandom_range(4095)), 1);
      for (int chip = 0; chip < NChips; chip++) begin
         last    = chip_vectors(chip);
         fail_at = (chip == target) ? last : $urandom_range(last - 1);
         for (int pos = 0; pos <= fail_at && pos < last; pos++) begin
            if ($urandom_range(149) == 0) begin
               send_beat(1'($urandom_range(1)), PinW'($urandom_range(4095)), 1);
               return;
            end
            send_beat(FUNC_SAMPLE,
                      sample_levels(chip, pos, pos != fail_at, PinW'($urandom_range(4095))), 1);
         end
         if (chip == target)
            return;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: samples while idle, start and restart, a full 7404 pass with unused pins
      // at both levels, an idle sample, then a first-vector mismatch that moves to the 7400
      send_beat(FUNC_SAMPLE, '0, 0);
      send_beat(FUNC_SAMPLE, ALL_HIGH, 0);
      send_beat(FUNC_START, ALL_HIGH, 1);
      send_beat(FUNC_START, '0, 1);
      for (int pos = 0; pos < chip_vectors(CHIP_7404); pos++)
         send_beat(FUNC_SAMPLE,
                   sample_levels(CHIP_7404, pos, 1'b1, pos[0] ? ALL_HIGH : '0), 1);
      send_beat(FUNC_SAMPLE, ALL_HIGH, 0);
      send_beat(FUNC_START, ALL_HIGH, 1);
      send_beat(FUNC_SAMPLE, sample_levels(CHIP_7404, 0, 1'b0, ALL_HIGH), 1);

      // Random identifications, idling phases rotating every three
      for (int run = 0; beats_sent < 1300; run++) begin
         case ((run / 3) % 4)
            0: begin
               sender_gap_pct = 0;
               stall_pct     <= 0;
            end
            1: begin
               sender_gap_pct = 48;
               stall_pct     <= 0;
            end
            2: begin
               sender_gap_pct = 0;
               stall_pct     <= 48;
            end
            default: begin
               sender_gap_pct = 26;
               stall_pct     <= 26;
            end
         endcase
         if (run % 9 == 4)
            hold_trigger <= hold_trigger + 1;
         if (run % 7 == 6)
            wait_until_drained();
         identify($urandom_range(CHIP_UNDEFINED));
         // stray samples, mostly while idle
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
               send_beat(FUNC_SAMPLE, PinW'($urandom_range(4095)), 0);
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ics_pkg.sv
hdl/ics_eval.sv
hdl/logic_ic_identifier_sequencer.sv
tb/ics_search_checker.sv
tb/tb_top.sv
